// ===== hdl/sssc_pkg.sv =====
// Package: shared types, character codes and name tables for the store scanner.
`default_nettype none

package sssc_pkg;

   // Default sizing, handed to the top level parameters as their defaults
   localparam int MAX_PENDING_DEF = 8;
   localparam int DEPTH_BITS_DEF  = 4;

   // Character codes
   localparam logic [7:0] CH_NUL    = 8'h00;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_EQ     = 8'h3D;
   localparam logic [7:0] CH_LBRACK = 8'h5B;
   localparam logic [7:0] CH_RBRACK = 8'h5D;
   localparam logic [7:0] CH_LPAREN = 8'h28;
   localparam logic [7:0] CH_RPAREN = 8'h29;
   localparam logic [7:0] CH_LOWER  = 8'h20;

   // Assignment lookahead states
   typedef enum logic [2:0] {
      LA_IDLE,
      LA_BLANKS,
      LA_OP,
      LA_OP_EQ,
      LA_EQ
   } la_state_type;

   // Request from the tokenizer to open a bracket check
   typedef struct packed {
      logic valid;
      logic paren;
   } open_req_type;

   // Link passed from cell to cell along the row
   typedef struct packed {
      logic grant;
      logic closed;
      logic ovf;
   } link_type;

   // Lower-case letters of the shared names; zero past the end of a name
   function automatic logic [7:0] reg_char(input logic [3:0] pos);
      logic [7:0] c;
      case (pos)
         4'd0:    c = "r";
         4'd1:    c = "e";
         4'd2:    c = "g";
         default: c = CH_NUL;
      endcase
      return c;
   endfunction

   function automatic logic [7:0] mega_char(input logic [3:0] pos);
      logic [7:0] c;
      case (pos)
         4'd0:    c = "m";
         4'd1:    c = "e";
         4'd2:    c = "g";
         4'd3:    c = "a";
         4'd4:    c = "b";
         4'd5:    c = "u";
         4'd6:    c = "f";
         default: c = CH_NUL;
      endcase
      return c;
   endfunction

   function automatic logic [7:0] gmega_char(input logic [3:0] pos);
      logic [7:0] c;
      case (pos)
         4'd0:    c = "g";
         4'd1:    c = "m";
         4'd2:    c = "e";
         4'd3:    c = "g";
         4'd4:    c = "a";
         4'd5:    c = "b";
         4'd6:    c = "u";
         4'd7:    c = "f";
         default: c = CH_NUL;
      endcase
      return c;
   endfunction

endpackage

`default_nettype wire

// ===== hdl/shared_store_assignment_scanner_top.sv =====
// Top level: shared-store assignment scanner with a row of bracket check cells.
`default_nettype none

// The scanner takes source text one byte per beat on the req_ channel and
// reports, on the zero byte that ends the text, one rsp_ beat: rsp_safe is 1
// when no store to reg##, megabuf or gmegabuf (any case, plain, indexed or
// called) was found, and rsp_gave_up is 1 when the row of MAX_PENDING
// bracket cells ran out or a nesting depth passed 2**DEPTH_BITS-1; the text
// is then reported unsafe. Each accepted byte is handled at once: the tokenizer,
// the lookahead and all cells update in the same cycle, and the grant that
// opens a new cell ripples along the row within that cycle. The result is
// registered and shows in the cycle after the zero byte is accepted; the next
// text can start in that same cycle. req_stall rises only while a finished
// result sits in the output register and rsp_stall holds it. After a result
// all scan state is back at its reset values.

module shared_store_assignment_scanner_top
   import sssc_pkg::*;
#(
   parameter int MAX_PENDING = MAX_PENDING_DEF,
   parameter int DEPTH_BITS  = DEPTH_BITS_DEF
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [7:0] req_ch,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic            rsp_safe,
   output logic            rsp_gave_up
);

   logic         accept, end_byte, step, finish;
   open_req_type open_req;
   logic         tok_unsafe;
   link_type     links [MAX_PENDING+1];
   logic         overflow_ff, overflow_in;
   logic         rsp_valid_ff, rsp_valid_in;
   logic         rsp_safe_ff, rsp_gave_up_ff;

   // Hold the input only while a result waits and the far side stalls
   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;
   assign end_byte  = (req_ch == CH_NUL);
   assign step      = accept & ~end_byte;
   assign finish    = accept & end_byte;

   sssc_tokenizer u_tokenizer (
      .clock    (clock),
      .reset    (reset),
      .step     (step),
      .clear    (finish),
      .ch       (req_ch),
      .closed   (links[MAX_PENDING].closed),
      .open_req (open_req),
      .unsafe   (tok_unsafe)
   );

   // The open grant enters at the head of the row; the first free cell takes it
   assign links[0].grant  = open_req.valid;
   assign links[0].closed = 1'b0;
   assign links[0].ovf    = 1'b0;

   for (genvar i = 0; i < MAX_PENDING; i++) begin : g_cell
      sssc_cell #(
         .DEPTH_BITS (DEPTH_BITS)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .step       (step),
         .clear      (finish),
         .ch         (req_ch),
         .open_paren (open_req.paren),
         .link_in    (links[i]),
         .link_out   (links[i+1])
      );
   end

   // A grant that leaves the row means no free cell
   always_comb begin
      overflow_in = overflow_ff;
      if (step && (links[MAX_PENDING].ovf || links[MAX_PENDING].grant)) begin
         overflow_in = 1'b1;
      end
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      if (finish) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || finish) begin
         overflow_ff <= 1'b0;
      end else begin
         overflow_ff <= overflow_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Load the result beat on the end byte
   always_ff @(posedge clock) begin
      if (finish) begin
         rsp_safe_ff    <= ~(tok_unsafe | overflow_ff);
         rsp_gave_up_ff <= overflow_ff;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_safe    = rsp_safe_ff;
   assign rsp_gave_up = rsp_gave_up_ff;

   // An accepted end byte always yields a result beat next cycle
   a_end_gives_result: assert property (@(posedge clock) disable iff (reset)
      finish |=> rsp_valid_ff)
      else $error("end byte accepted without a result beat");

   // Overflow state starts clean for every text
   a_overflow_cleared: assert property (@(posedge clock) disable iff (reset)
      finish |=> !overflow_ff)
      else $error("overflow flag survived the end of text");

   // A given-up result is never reported safe
   a_gave_up_unsafe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_safe_ff && rsp_gave_up_ff))
      else $error("result both safe and gave_up");

   // Input back-pressure only comes from a held result
   a_stall_source: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid_ff)
      else $error("input stalled with no pending result");

endmodule

`default_nettype wire

// ===== hdl/sssc_cell.sv =====
// Module: one pending bracket check cell of the row.
`default_nettype none

module sssc_cell
   import sssc_pkg::*;
#(
   parameter int DEPTH_BITS = DEPTH_BITS_DEF
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       step,
   input  wire logic       clear,
   input  wire logic [7:0] ch,
   input  wire logic       open_paren,
   input  wire link_type   link_in,
   output link_type        link_out
);

   localparam logic [DEPTH_BITS-1:0] DepthOne = DEPTH_BITS'(1);
   localparam logic [DEPTH_BITS-1:0] DepthMax = '1;

   logic                  active_ff, active_in;
   logic                  paren_ff, paren_in;
   logic [DEPTH_BITS-1:0] depth_ff, depth_in;

   logic                  act_upd;
   logic [DEPTH_BITS-1:0] dep_upd;
   logic                  ovf_here, close_here, is_opener, is_closer, take;

   always_comb begin
      is_opener  = paren_ff ? (ch == CH_LPAREN) : (ch == CH_LBRACK);
      is_closer  = paren_ff ? (ch == CH_RPAREN) : (ch == CH_RBRACK);
      act_upd    = active_ff;
      dep_upd    = depth_ff;
      ovf_here   = 1'b0;
      close_here = 1'b0;
      if (active_ff) begin
         if (is_opener) begin
            if (depth_ff == DepthMax) begin
               ovf_here = 1'b1;
               act_upd  = 1'b0;
            end else begin
               dep_upd = depth_ff + DepthOne;
            end
         end else if (is_closer) begin
            dep_upd = depth_ff - DepthOne;
            if (depth_ff == DepthOne) begin
               act_upd    = 1'b0;
               close_here = 1'b1;
            end
         end
      end

      // Take the open grant when free after this beat, else pass it on
      take            = link_in.grant & ~act_upd;
      link_out.grant  = link_in.grant & act_upd;
      link_out.closed = link_in.closed | close_here;
      link_out.ovf    = link_in.ovf | ovf_here;

      active_in = active_ff;
      paren_in  = paren_ff;
      depth_in  = depth_ff;
      if (step) begin
         if (take) begin
            active_in = 1'b1;
            paren_in  = open_paren;
            depth_in  = DepthOne;
         end else begin
            active_in = act_upd;
            depth_in  = dep_upd;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         active_ff <= 1'b0;
      end else begin
         active_ff <= active_in;
      end
   end

   always_ff @(posedge clock) begin
      paren_ff <= paren_in;
      depth_ff <= depth_in;
   end

endmodule

`default_nettype wire

// ===== hdl/sssc_tokenizer.sv =====
// Module: identifier matcher, buffer-name wait and assignment lookahead.
`default_nettype none

module sssc_tokenizer
   import sssc_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       step,
   input  wire logic       clear,
   input  wire logic [7:0] ch,
   input  wire logic       closed,
   output open_req_type    open_req,
   output logic            unsafe
);

   logic         prev_ident_ff, prev_ident_in;
   logic [3:0]   ident_len_ff, ident_len_in;
   logic [2:0]   flags_ff, flags_in;
   logic         name_wait_ff, name_wait_in;
   la_state_type la_state_ff, la_state_in;
   logic         unsafe_ff, unsafe_in;

   logic         is_id, is_blank, is_opch, is_eq, is_digit, is_bracket;
   logic [7:0]   lc;
   logic [3:0]   base_len;
   logic [2:0]   base_flags;
   logic         r_ok, m_ok, g_ok;
   logic         ended, reg_hit, mega_hit, name_trig, la_start;
   la_state_type start_state, fed_state;

   always_comb begin
      is_digit   = (ch >= "0") && (ch <= "9");
      is_id      = ((ch >= "a") && (ch <= "z")) || ((ch >= "A") && (ch <= "Z")) ||
                   is_digit || (ch == "_");
      is_blank   = (ch == CH_SPACE) || (ch == CH_TAB);
      is_opch    = (ch == "+") || (ch == "-") || (ch == "*") || (ch == "/") ||
                   (ch == "%") || (ch == "|") || (ch == "&") || (ch == "^");
      is_eq      = (ch == CH_EQ);
      is_bracket = (ch == CH_LBRACK) || (ch == CH_LPAREN);
      lc         = ch | CH_LOWER;

      // Identifier tracking
      base_len   = prev_ident_ff ? ident_len_ff : 4'd0;
      base_flags = prev_ident_ff ? flags_ff : 3'b111;
      r_ok       = (base_len < 4'd3) ? (lc == reg_char(base_len)) :
                   ((base_len < 4'd5) && is_digit);
      m_ok       = (lc == mega_char(base_len));
      g_ok       = (lc == gmega_char(base_len));

      // A name ends at the first non-identifier byte
      ended     = prev_ident_ff & ~is_id;
      reg_hit   = ended & flags_ff[0] & (ident_len_ff == 4'd5);
      mega_hit  = ended & ((flags_ff[1] & (ident_len_ff == 4'd7)) |
                           (flags_ff[2] & (ident_len_ff == 4'd8)));
      name_trig = name_wait_ff | mega_hit;
      la_start  = reg_hit | (name_trig & ~is_blank & ~is_bracket);

      open_req.valid = step & name_trig & is_bracket;
      open_req.paren = (ch == CH_LPAREN);

      // Lookahead entered fresh on this byte
      if (is_blank) begin
         start_state = LA_BLANKS;
      end else if (is_opch) begin
         start_state = LA_OP;
      end else if (is_eq) begin
         start_state = LA_EQ;
      end else begin
         start_state = LA_IDLE;
      end

      unsafe_in = unsafe_ff;
      unique case (la_state_ff)
         LA_IDLE:   fed_state = LA_IDLE;
         LA_BLANKS: fed_state = start_state;
         LA_OP:     fed_state = is_eq ? LA_OP_EQ : LA_IDLE;
         LA_OP_EQ, LA_EQ: begin
            fed_state = LA_IDLE;
            if (!is_eq) begin
               unsafe_in = 1'b1;
            end
         end
         default:   fed_state = LA_IDLE;
      endcase

      if (closed) begin
         la_state_in = LA_BLANKS;
      end else if (la_start) begin
         la_state_in = start_state;
      end else begin
         la_state_in = fed_state;
      end

      prev_ident_in = is_id;
      ident_len_in  = ident_len_ff;
      flags_in      = flags_ff;
      if (is_id) begin
         ident_len_in = (base_len == 4'd15) ? base_len : base_len + 4'd1;
         flags_in     = base_flags & {g_ok, m_ok, r_ok};
      end
      name_wait_in = name_trig & is_blank;

      // End of text still counts a pending '=' or op=
      unsafe = unsafe_ff | (la_state_ff == LA_OP_EQ) || (la_state_ff == LA_EQ);
   end

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         la_state_ff <= LA_IDLE;
      end else if (step) begin
         la_state_ff <= la_state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         prev_ident_ff <= 1'b0;
         ident_len_ff  <= 4'd0;
         flags_ff      <= 3'b000;
         name_wait_ff  <= 1'b0;
         unsafe_ff     <= 1'b0;
      end else if (step) begin
         prev_ident_ff <= prev_ident_in;
         ident_len_ff  <= ident_len_in;
         flags_ff      <= flags_in;
         name_wait_ff  <= name_wait_in;
         unsafe_ff     <= unsafe_in;
      end
   end

endmodule

`default_nettype wire

// ===== test/shared_store_assignment_scanner_top_tb.sv =====
// Testbench: byte-stream stimulus and a bit-level predictor for the store scanner.
`timescale 1ns / 100ps

module shared_store_assignment_scanner_top_tb;
   import sssc_pkg::*;

   // Sizing of the block under test and of the predictor
   localparam int N_CELLS     = MAX_PENDING_DEF;
   localparam int DEPTH_LIMIT = (1 << DEPTH_BITS_DEF) - 1;
   localparam int CYCLE_LIMIT = 500000;
   localparam int RAND_BYTES  = 80;

   // Name-match flags
   localparam bit [2:0] M_REG   = 3'b001;
   localparam bit [2:0] M_MEGA  = 3'b010;
   localparam bit [2:0] M_GMEGA = 3'b100;

   // Expectation codes of the directed table: {typed, safe, gave_up}
   localparam bit [2:0] EXP_PREDICT = 3'b000;
   localparam bit [2:0] EXP_SAFE    = 3'b110;
   localparam bit [2:0] EXP_STORE   = 3'b100;
   localparam bit [2:0] EXP_GAVE_UP = 3'b101;

   localparam int N_DIR = 24;

   // Directed texts; the zero byte that ends each one is appended on send.
   string dir_text [N_DIR] = '{
      "",
      "reg01=1",
      "ReG99\t+=",
      "reg55 -",
      "reg7=",
      "reg123=1",
      "a==reg00==b",
      "MEGABUF[i]=x",
      "gmegabuf(a(b)) ^= 1",
      "megabuf[[0]",
      "megabuf(x]=1",
      "megabuf \t",
      "gmegabuf",
      "megabuf[[[[[[[[[[[[[[[[",
      "megabuf(megabuf(megabuf(megabuf(megabuf(megabuf(megabuf(megabuf(megabuf(",
      "x_megabuf=1 gmegabuf2=1 megabu=1",
      "reg0\3001=",
      "reg01\377=1",
      "megabuf[reg11=2]",
      "megabuf[0] \t%==3",
      "reg01+ reg02- reg03* reg04/ reg05% reg06| reg07& reg08^ ",
      "gMegaBuf(1)",
      "megabuf[1]=",
      "(megabuf[a[b]]]) = c"
   };

   bit [2:0] dir_exp [N_DIR] = '{
      EXP_SAFE,    EXP_STORE,   EXP_STORE,   EXP_SAFE,    EXP_SAFE,    EXP_SAFE,
      EXP_SAFE,    EXP_STORE,   EXP_STORE,   EXP_SAFE,    EXP_SAFE,    EXP_SAFE,
      EXP_SAFE,    EXP_GAVE_UP, EXP_GAVE_UP, EXP_SAFE,    EXP_SAFE,    EXP_PREDICT,
      EXP_STORE,   EXP_SAFE,    EXP_SAFE,    EXP_SAFE,    EXP_STORE,   EXP_PREDICT
   };

   // DUT connections
   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_stall;
   logic [7:0] req_ch;
   logic       rsp_valid;
   logic       rsp_stall;
   logic       rsp_safe;
   logic       rsp_gave_up;

   shared_store_assignment_scanner_top u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_ch      (req_ch),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_safe    (rsp_safe),
      .rsp_gave_up (rsp_gave_up)
   );

   // Predictor state: tokenizer, lookahead, bracket cells, sticky flags
   bit           scan_prev_word;
   bit [3:0]     scan_len;
   bit [2:0]     scan_flags;
   bit           scan_name_wait;
   la_state_type scan_la;
   bit           cell_busy  [N_CELLS];
   bit           cell_paren [N_CELLS];
   bit [DEPTH_BITS_DEF:0] cell_depth [N_CELLS];
   bit           scan_unsafe;
   bit           scan_ovf;

   string name_reg   = "reg";
   string name_mega  = "megabuf";
   string name_gmega = "gmegabuf";
   string op_chars   = "+-*/%|&^";
   string word_chars = "abcgxyzREGM_019ufe";

   // Expected {safe, gave_up} per text, oldest first
   bit [1:0] store_verdicts [$];
   bit [1:0] want;

   // Bytes of the text being built
   bit [7:0] text_q [$];

   // Directed rows override the predicted verdict with the typed one
   bit       typed_on;
   bit [1:0] typed_val;

   int  errors;
   int  cycles;
   int  hold_cnt;
   int  rand_bytes;
   bit  quiet;

   task report_mismatch(input string msg);
      errors++;
      if (errors <= 30) $display("[%0t] mismatch: %s", $time, msg);
   endtask

   // ---------------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------------
   function automatic void scan_clear();
      scan_prev_word = 1'b0;
      scan_len       = '0;
      scan_flags     = '0;
      scan_name_wait = 1'b0;
      scan_la        = LA_IDLE;
      for (int i = 0; i < N_CELLS; i++) begin
         cell_busy[i]  = 1'b0;
         cell_paren[i] = 1'b0;
         cell_depth[i] = '0;
      end
      scan_unsafe = 1'b0;
      scan_ovf    = 1'b0;
   endfunction

   function automatic bit is_word(input bit [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") ||
             (c >= "0" && c <= "9") || c == "_";
   endfunction

   function automatic bit is_blank(input bit [7:0] c);
      return c == CH_SPACE || c == CH_TAB;
   endfunction

   function automatic bit is_op(input bit [7:0] c);
      bit hit;
      hit = 1'b0;
      for (int i = 0; i < op_chars.len(); i++)
         if (c == op_chars[i]) hit = 1'b1;
      return hit;
   endfunction

   // Advance the assignment lookahead by one byte
   function automatic void la_step(input bit [7:0] c);
      case (scan_la)
         LA_BLANKS: begin
            if (!is_blank(c)) begin
               if (is_op(c))        scan_la = LA_OP;
               else if (c == CH_EQ) scan_la = LA_EQ;
               else                 scan_la = LA_IDLE;
            end
         end
         LA_OP: scan_la = (c == CH_EQ) ? LA_OP_EQ : LA_IDLE;
         LA_OP_EQ, LA_EQ: begin
            if (c != CH_EQ) scan_unsafe = 1'b1;
            scan_la = LA_IDLE;
         end
         default: scan_la = LA_IDLE;
      endcase
   endfunction

   function automatic void la_begin(input bit [7:0] c);
      scan_la = LA_BLANKS;
      la_step(c);
   endfunction

   function automatic void claim_cell(input bit paren);
      bit done;
      done = 1'b0;
      for (int i = 0; i < N_CELLS; i++) begin
         if (!done && !cell_busy[i]) begin
            cell_busy[i]  = 1'b1;
            cell_paren[i] = paren;
            cell_depth[i] = {{DEPTH_BITS_DEF{1'b0}}, 1'b1};
            done          = 1'b1;
         end
      end
      if (!done) scan_ovf = 1'b1;
   endfunction

   function automatic void name_step(input bit [7:0] c);
      if (!is_blank(c)) begin
         scan_name_wait = 1'b0;
         if (c == CH_LBRACK)      claim_cell(1'b0);
         else if (c == CH_LPAREN) claim_cell(1'b1);
         else                     la_begin(c);
      end
   endfunction

   function automatic void word_extend(input bit [7:0] c);
      int       pos;
      bit [7:0] lc;
      bit       r, m, g;
      pos = int'(scan_len);
      lc  = c | CH_LOWER;
      if (pos < 3)      r = (lc == name_reg[pos]);
      else if (pos < 5) r = (c >= "0" && c <= "9");
      else              r = 1'b0;
      m = (pos < 7) ? (lc == name_mega[pos])  : 1'b0;
      g = (pos < 8) ? (lc == name_gmega[pos]) : 1'b0;
      if (!r) scan_flags &= ~M_REG;
      if (!m) scan_flags &= ~M_MEGA;
      if (!g) scan_flags &= ~M_GMEGA;
      if (scan_len < 15) scan_len++;
   endfunction

   // One accepted byte; a zero byte yields the verdict {safe, gave_up}
   function automatic void scan_char(input bit [7:0] c, output bit got,
                                     output bit [1:0] verdict);
      bit       closed;
      bit [7:0] opn, cls;
      closed  = 1'b0;
      got     = 1'b0;
      verdict = '0;
      if (c == CH_NUL) begin
         if (scan_la == LA_OP_EQ || scan_la == LA_EQ) scan_unsafe = 1'b1;
         verdict = {!(scan_unsafe || scan_ovf), scan_ovf};
         got     = 1'b1;
         scan_clear();
         return;
      end
      for (int i = 0; i < N_CELLS; i++) begin
         if (cell_busy[i]) begin
            opn = cell_paren[i] ? CH_LPAREN : CH_LBRACK;
            cls = cell_paren[i] ? CH_RPAREN : CH_RBRACK;
            if (c == opn) begin
               if (cell_depth[i] >= DEPTH_LIMIT) begin
                  scan_ovf      = 1'b1;
                  cell_busy[i]  = 1'b0;
                  cell_depth[i] = '0;
               end else begin
                  cell_depth[i]++;
               end
            end else if (c == cls) begin
               cell_depth[i]--;
               if (cell_depth[i] == 0) begin
                  cell_busy[i] = 1'b0;
                  closed       = 1'b1;
               end
            end
         end
      end
      if (scan_la != LA_IDLE) la_step(c);
      if (scan_name_wait) name_step(c);
      if (is_word(c)) begin
         if (!scan_prev_word) begin
            scan_len   = '0;
            scan_flags = M_REG | M_MEGA | M_GMEGA;
         end
         word_extend(c);
         scan_prev_word = 1'b1;
      end else begin
         if (scan_prev_word) begin
            if ((scan_flags & M_REG) != 0 && scan_len == 5) begin
               la_begin(c);
            end else if (((scan_flags & M_MEGA) != 0 && scan_len == 7) ||
                         ((scan_flags & M_GMEGA) != 0 && scan_len == 8)) begin
               scan_name_wait = 1'b1;
               name_step(c);
            end
         end
         scan_prev_word = 1'b0;
      end
      if (closed) scan_la = LA_BLANKS;
   endfunction

   // ---------------------------------------------------------------------
   // Random text builders
   // ---------------------------------------------------------------------
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 12);
      return $urandom_range(25, 60);
   endfunction

   // Push a name with each letter in random case
   function automatic void put_name(input string s);
      bit [7:0] c;
      for (int i = 0; i < s.len(); i++) begin
         c = s[i];
         if (c >= "a" && c <= "z" && $urandom_range(0, 1)) c = c & ~CH_LOWER;
         text_q.push_back(c);
      end
   endfunction

   function automatic void put_digit();
      text_q.push_back(8'("0" + $urandom_range(0, 9)));
   endfunction

   function automatic void put_word();
      int n;
      n = $urandom_range(1, 6);
      repeat (n) text_q.push_back(word_chars[$urandom_range(0, word_chars.len() - 1)]);
   endfunction

   function automatic void put_blanks();
      int n;
      n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
      repeat (n) text_q.push_back($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
   endfunction

   function automatic void put_op();
      text_q.push_back(op_chars[$urandom_range(0, 7)]);
   endfunction

   function automatic void put_buffer();
      put_name($urandom_range(0, 1) ? name_mega : name_gmega);
   endfunction

   // Shared name or a near miss; returns 1 for a buffer name
   function automatic bit put_target();
      int r;
      r = $urandom_range(0, 9);
      if (r < 4) begin
         put_name(name_reg);
         put_digit();
         put_digit();
         return 1'b0;
      end
      if (r < 8) begin
         put_buffer();
         return 1'b1;
      end
      case ($urandom_range(0, 4))
         0: begin put_name(name_reg); put_digit(); end
         1: begin put_name(name_reg); put_digit(); put_digit(); put_digit(); end
         2: put_name("megabu");
         3: put_name("megabuff");
         default: begin put_name("xgmegabuf"); end
      endcase
      return 1'b0;
   endfunction

   function automatic void put_assign();
      case ($urandom_range(0, 9))
         0, 1, 2: text_q.push_back(CH_EQ);
         3, 4, 5: begin put_op(); text_q.push_back(CH_EQ); end
         6: begin text_q.push_back(CH_EQ); text_q.push_back(CH_EQ); end
         7: begin put_op(); text_q.push_back(CH_EQ); text_q.push_back(CH_EQ); end
         8: put_op();
         default: text_q.push_back($urandom_range(0, 1) ? "<" : "!");
      endcase
   endfunction

   function automatic void put_bracket(input bit paren, input int lvl);
      int n;
      text_q.push_back(paren ? CH_LPAREN : CH_LBRACK);
      n = $urandom_range(0, 3);
      for (int i = 0; i < n; i++) begin
         case ($urandom_range(0, 5))
            0, 1: put_word();
            2: if (lvl < 3) put_bracket(paren, lvl + 1);
            3: text_q.push_back(paren ? CH_RBRACK : CH_RPAREN);
            4: begin void'(put_target()); put_assign(); put_digit(); end
            default: text_q.push_back(CH_SPACE);
         endcase
      end
      if ($urandom_range(0, 99) < 85) text_q.push_back(paren ? CH_RPAREN : CH_RBRACK);
   endfunction

   function automatic void put_statement();
      bit buffer;
      if ($urandom_range(0, 9) < 3) begin
         put_word();
         text_q.push_back($urandom_range(0, 1) ? CH_SPACE : CH_EQ);
      end
      buffer = put_target();
      put_blanks();
      if (buffer && $urandom_range(0, 9) < 6) begin
         put_bracket(1'($urandom_range(0, 1)), 0);
         put_blanks();
      end
      if ($urandom_range(0, 9) == 0) return;
      put_assign();
      if ($urandom_range(0, 4) == 0) return;
      put_blanks();
      if ($urandom_range(0, 1)) put_word();
      else put_digit();
   endfunction

   function automatic void build_random_text();
      int r;
      text_q.delete();
      r = $urandom_range(0, 99);
      if (r < 6) begin
         // raw noise: any nonzero byte
         repeat ($urandom_range(1, 12)) text_q.push_back(8'($urandom_range(1, 255)));
      end else if (r < 9) begin
         // exhaust the bracket cells
         repeat ($urandom_range(N_CELLS, N_CELLS + 2)) begin
            put_buffer();
            text_q.push_back($urandom_range(0, 1) ? CH_LPAREN : CH_LBRACK);
         end
      end else if (r < 12) begin
         // nest close to or past the depth limit
         put_buffer();
         repeat ($urandom_range(DEPTH_LIMIT - 2, DEPTH_LIMIT + 2))
            text_q.push_back(CH_LBRACK);
         repeat ($urandom_range(0, DEPTH_LIMIT)) text_q.push_back(CH_RBRACK);
         if ($urandom_range(0, 1)) text_q.push_back(CH_EQ);
      end else begin
         repeat ($urandom_range(1, 3)) begin
            put_statement();
            case ($urandom_range(0, 3))
               0: text_q.push_back(";");
               1: text_q.push_back(CH_SPACE);
               2: text_q.push_back(8'h0A);
               default: text_q.push_back(8'($urandom_range(1, 255)));
            endcase
         end
      end
   endfunction

   // ---------------------------------------------------------------------
   // Clock, reset, cycle limit
   // ---------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Calm windows: neither side idles nor stalls
   always @(posedge clock) begin
      cycles <= cycles + 1;
      quiet  <= ((cycles % 600) < 100);
      if (cycles > CYCLE_LIMIT) begin
         $display("[shared_store_assignment_scanner_top] ERROR");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Result side: random stall, compare each beat with the oldest verdict
   // ---------------------------------------------------------------------
   initial begin
      rsp_stall = 1'b0;
      hold_cnt  = 0;
      forever begin
         @(negedge clock);
         if (hold_cnt == 0 && !quiet && $urandom_range(0, 99) < 30)
            hold_cnt = ($urandom_range(0, 99) < 90) ? $urandom_range(1, 4)
                                                    : $urandom_range(20, 60);
         rsp_stall <= (hold_cnt != 0);
         if (hold_cnt > 0) hold_cnt--;
      end
   end

   always @(posedge clock) begin
      if (reset === 1'b0 && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (store_verdicts.size() == 0) begin
            report_mismatch("result beat with no verdict pending");
         end else begin
            want = store_verdicts.pop_front();
            if (rsp_safe !== want[1])
               report_mismatch($sformatf("safe %b, want %b", rsp_safe, want[1]));
            if (rsp_gave_up !== want[0])
               report_mismatch($sformatf("gave_up %b, want %b", rsp_gave_up, want[0]));
         end
      end
   end

   // ---------------------------------------------------------------------
   // Request side
   // ---------------------------------------------------------------------

   // Drive one byte, hold it until accepted, then run it through the predictor
   task automatic send_byte(input bit [7:0] b);
      int       gap;
      bit       got;
      bit [1:0] verdict;
      gap = quiet ? 0 : pick_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_ch    <= b;
      do @(posedge clock); while (req_stall !== 1'b0);
      scan_char(b, got, verdict);
      if (got) store_verdicts.push_back(typed_on ? typed_val : verdict);
   endtask

   // Send the built text followed by its terminating zero byte
   task automatic send_text();
      foreach (text_q[i]) send_byte(text_q[i]);
      send_byte(CH_NUL);
   endtask

   // Drop valid and hold off until every verdict has come back
   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (store_verdicts.size() != 0) @(posedge clock);
   endtask

   initial begin
      reset     = 1'b1;
      req_valid = 1'b0;
      req_ch    = CH_NUL;
      errors    = 0;
      typed_on  = 1'b0;
      typed_val = '0;
      scan_clear();
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed table: typed verdict where given, predictor otherwise
      for (int t = 0; t < N_DIR; t++) begin
         text_q.delete();
         for (int i = 0; i < dir_text[t].len(); i++) text_q.push_back(dir_text[t][i]);
         typed_on  = dir_exp[t][2];
         typed_val = dir_exp[t][1:0];
         send_text();
      end
      typed_on = 1'b0;
      drain();

      // Random texts, mostly well-formed statements with random content
      rand_bytes = 0;
      while (rand_bytes < RAND_BYTES) begin
         build_random_text();
         rand_bytes += text_q.size() + 1;
         send_text();
         if ($urandom_range(0, 99) < 12) drain();
      end

      // Let the last verdict arrive, then watch for stray beats
      drain();
      repeat (8) @(posedge clock);
      if (errors == 0 && store_verdicts.size() == 0) begin
         $display("[shared_store_assignment_scanner_top] OK");
      end else begin
         $display("[shared_store_assignment_scanner_top] ERROR");
      end
      $finish;
   end

endmodule

// ===== shared_store_assignment_scanner_top.f =====
hdl/sssc_pkg.sv
hdl/sssc_cell.sv
hdl/sssc_tokenizer.sv
hdl/shared_store_assignment_scanner_top.sv
test/shared_store_assignment_scanner_top_tb.sv
